// ----- src/epfm_pkg.sv -----
// shared types and constants of the encoder period and frequency meter
// no dependencies; used by the interfaces and every module under src

package epfm_pkg;

	// widths of the item fields and registers
	localparam int TIME_W   = 48;
	localparam int MAG_W    = 31;
	localparam int PERIOD_W = 32;
	localparam int FREQ_W   = 29;
	localparam int DEB_W    = 16;
	localparam int MAXP_W   = 24;
	localparam int MINP_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// 1e6 Hz*us scaled by 2^8 fraction bits: quotient is the Q8 frequency
	localparam int QUO_W = 28;
	localparam logic [QUO_W-1:0] FREQ_NUM_Q8 = 28'd256000000;
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'(QUO_W);

	// largest period magnitude before saturation
	localparam logic [MAG_W-1:0] PERIOD_SAT = '1;

	// register reset values
	localparam logic [DEB_W-1:0]  DEB_RESET  = '0;
	localparam logic [MAXP_W-1:0] MAXP_RESET = 24'd1000000;
	localparam logic [MINP_W-1:0] MINP_RESET = 16'd1;

	// register indexes on the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_MAX_PERIOD = 2'd1,
		REG_MIN_PERIOD = 2'd2
	} cfg_reg_t;

	// action codes of an input item
	typedef enum logic {
		ACT_EDGE  = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_TIMEOUT   = 2'd1,
		ST_BELOW_MIN = 2'd2,
		ST_NO_PERIOD = 2'd3
	} status_t;

	// current register values handed to the datapath
	typedef struct packed {
		logic [DEB_W-1:0]  debounce_us;
		logic [MAXP_W-1:0] max_period_us;
		logic [MINP_W-1:0] min_period_us;
	} cfg_regs_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE,
		S_UPDATE,
		S_CHECK,
		S_DIVIDE,
		S_FINISH
	} state_t;

endpackage

// ----- src/epfm_if.sv -----
// channel interfaces: input item, result item and configuration write
// depends on epfm_pkg for field widths

interface epfm_req_if;
	logic                              valid;
	logic                              ready;
	logic                              action;
	logic [epfm_pkg::TIME_W-1:0]       now_us;
	logic                              level_b;

	modport source (output valid, action, now_us, level_b, input ready);
	modport sink   (input valid, action, now_us, level_b, output ready);
endinterface

interface epfm_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [epfm_pkg::FREQ_W-1:0]  freq_q8;
	logic signed [epfm_pkg::PERIOD_W-1:0] period_us;
	logic [1:0]                          status;
	logic                                edge_accepted;

	modport source (output valid, freq_q8, period_us, status, edge_accepted, input ready);
	modport sink   (input valid, freq_q8, period_us, status, edge_accepted, output ready);
endinterface

interface epfm_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [epfm_pkg::CFG_IDX_W-1:0]      index;
	logic [epfm_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/epfm_cfg.sv -----
// configuration register file: debounce, timeout and minimum period
// depends on epfm_pkg and epfm_cfg_if

module epfm_cfg (
	input  logic                clk,
	input  logic                arst_n,
	epfm_cfg_if.sink            cfg,
	output epfm_pkg::cfg_regs_t regs
);

	epfm_pkg::cfg_regs_t regs_q;

	// writes are always taken
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	// register write, keeping only each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.debounce_us   <= epfm_pkg::DEB_RESET;
			regs_q.max_period_us <= epfm_pkg::MAXP_RESET;
			regs_q.min_period_us <= epfm_pkg::MINP_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				epfm_pkg::REG_DEBOUNCE:
					regs_q.debounce_us <= cfg.data[epfm_pkg::DEB_W-1:0];
				epfm_pkg::REG_MAX_PERIOD:
					regs_q.max_period_us <= cfg.data[epfm_pkg::MAXP_W-1:0];
				epfm_pkg::REG_MIN_PERIOD:
					regs_q.min_period_us <= cfg.data[epfm_pkg::MINP_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ----- src/epfm_div.sv -----
// bit-serial restoring divider: constant Q8 numerator over period magnitude
// depends on epfm_pkg; one quotient bit per cycle

module epfm_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [epfm_pkg::MAG_W-1:0]         divisor,
	output logic                               done,
	output logic [epfm_pkg::QUO_W-1:0]         quotient
);

	logic [epfm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [epfm_pkg::MAG_W-1:0]     rem_q;
	logic [epfm_pkg::QUO_W-1:0]     dq_q;
	logic [epfm_pkg::MAG_W:0]       trial;
	logic                           fits;

	// shift in the next numerator bit and try the subtraction
	assign trial = {rem_q, dq_q[epfm_pkg::QUO_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	assign done     = done_q;
	assign quotient = dq_q;

	// step counter and completion flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == epfm_pkg::DIV_CNT_W'(1));
			if (start)
				cnt_q <= epfm_pkg::DIV_STEPS;
			else if (cnt_q != '0)
				cnt_q <= cnt_q - epfm_pkg::DIV_CNT_W'(1);
		end
	end

	// remainder and numerator/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= epfm_pkg::FREQ_NUM_Q8;
		end else if (cnt_q != '0) begin
			if (fits)
				rem_q <= epfm_pkg::MAG_W'(trial - {1'b0, divisor});
			else
				rem_q <= trial[epfm_pkg::MAG_W-1:0];
			dq_q <= {dq_q[epfm_pkg::QUO_W-2:0], fits};
		end
	end

endmodule

// ----- src/encoder_period_frequency_meter.sv -----
// encoder period and frequency meter, top level with the item sequencer
// depends on epfm_pkg, epfm_if, epfm_cfg and epfm_div
//
// Usage:
//   req carries one item per edge of encoder channel A (action 0) or a query
//   (action 1), with a microsecond timestamp and the level of channel B.
//   rsp returns exactly one item for each req item: signed Q8 frequency,
//   stored signed period, status and whether the edge passed debounce.
//   cfg writes debounce_us (index 0), max_period_us (1), min_period_us (2);
//   it is always ready and should only be written while the block is idle.
// Timing:
//   an item is processed one at a time; req.ready is high only when idle.
//   A valid frequency passes through the 28 steps of the bit-serial divider
//   between acceptance and rsp.valid; timed-out, below-minimum and
//   zero-period items skip the divider. The next item is accepted the cycle
//   after the result is loaded into the output register.
// Reset:
//   arst_n clears the stored period and last edge time to zero and loads
//   the register defaults (0, 1000000, 1).
// Stall:
//   a finished result waits in the output register; the following result
//   waits in the sequencer until that register is taken.

module encoder_period_frequency_meter (
	input  logic       clk,
	input  logic       arst_n,
	epfm_req_if.sink   req,
	epfm_rsp_if.source rsp,
	epfm_cfg_if.sink   cfg
);

	epfm_pkg::cfg_regs_t regs;
	epfm_pkg::state_t    state_q, state_d;

	// captured item
	logic                               action_q;
	logic [epfm_pkg::TIME_W-1:0]        now_q;
	logic                               level_q;

	// persistent state: period as sign and magnitude, last edge time
	logic [epfm_pkg::TIME_W-1:0]        last_q;
	logic [epfm_pkg::MAG_W-1:0]         mag_q;
	logic                               neg_q;

	// per item working registers
	logic                               acc_q;
	logic [epfm_pkg::TIME_W-1:0]        diff_q;
	epfm_pkg::status_t                  status_q;
	logic                               out_valid_q;

	logic                               edge_ok;
	logic                               timeout;
	logic                               below_min;
	logic                               freq_ok;
	logic                               div_start;
	logic                               div_done;
	logic [epfm_pkg::QUO_W-1:0]         quotient;
	logic                               load_out;
	logic [epfm_pkg::FREQ_W-1:0]        fmag;
	logic [epfm_pkg::PERIOD_W-1:0]      pmag;

	epfm_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	epfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (mag_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// debounce window and timeout window compares
	assign edge_ok = (action_q == epfm_pkg::ACT_EDGE) &&
		({1'b0, now_q} > ({1'b0, last_q} + {33'b0, regs.debounce_us}));
	assign timeout = {1'b0, now_q} > ({1'b0, last_q} + {25'b0, regs.max_period_us});
	assign below_min = mag_q < {15'b0, regs.min_period_us};
	assign freq_ok   = !timeout && !below_min && (mag_q != '0);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			epfm_pkg::S_IDLE:   if (req.valid) state_d = epfm_pkg::S_EDGE;
			epfm_pkg::S_EDGE:   state_d = epfm_pkg::S_UPDATE;
			epfm_pkg::S_UPDATE: state_d = epfm_pkg::S_CHECK;
			epfm_pkg::S_CHECK:
				state_d = freq_ok ? epfm_pkg::S_DIVIDE : epfm_pkg::S_FINISH;
			epfm_pkg::S_DIVIDE: if (div_done) state_d = epfm_pkg::S_FINISH;
			epfm_pkg::S_FINISH:
				if (!out_valid_q || rsp.ready) state_d = epfm_pkg::S_IDLE;
			default:            state_d = epfm_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req.ready = (state_q == epfm_pkg::S_IDLE);
		div_start = (state_q == epfm_pkg::S_CHECK) && freq_ok;
		load_out  = (state_q == epfm_pkg::S_FINISH) && (!out_valid_q || rsp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= epfm_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	// item capture, edge qualification, difference and status
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_q <= req.action;
			now_q    <= req.now_us;
			level_q  <= req.level_b;
		end
		if (state_q == epfm_pkg::S_EDGE) begin
			acc_q  <= edge_ok;
			diff_q <= now_q - last_q;
		end
		if (state_q == epfm_pkg::S_CHECK) begin
			priority if (timeout)
				status_q <= epfm_pkg::ST_TIMEOUT;
			else if (below_min)
				status_q <= epfm_pkg::ST_BELOW_MIN;
			else if (mag_q == '0)
				status_q <= epfm_pkg::ST_NO_PERIOD;
			else
				status_q <= epfm_pkg::ST_VALID;
		end
	end

	// stored period and last edge time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
			mag_q  <= '0;
			neg_q  <= 1'b0;
		end else if (state_q == epfm_pkg::S_UPDATE && acc_q) begin
			last_q <= now_q;
			neg_q  <= level_q;
			if (diff_q > {17'b0, epfm_pkg::PERIOD_SAT})
				mag_q <= epfm_pkg::PERIOD_SAT;
			else
				mag_q <= diff_q[epfm_pkg::MAG_W-1:0];
		end else if (state_q == epfm_pkg::S_CHECK && !timeout && below_min) begin
			mag_q <= '0;
			neg_q <= 1'b0;
		end
	end

	// signed result values
	assign fmag = {1'b0, quotient};
	assign pmag = {1'b0, mag_q};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (status_q == epfm_pkg::ST_VALID)
				rsp.freq_q8 <= neg_q ? -fmag : fmag;
			else
				rsp.freq_q8 <= '0;
			rsp.period_us     <= neg_q ? -pmag : pmag;
			rsp.status        <= status_q;
			rsp.edge_accepted <= acc_q;
		end
	end

	assign rsp.valid = out_valid_q;

endmodule

// ----- tb/epfm_checker.sv -----
// result checker of the encoder period and frequency meter: predicts every reading
// depends on epfm_pkg and the channel interfaces in epfm_if
`timescale 1ns / 100ps

module epfm_checker (
	input  logic clk,
	input  logic arst_n,
	epfm_req_if  req,
	epfm_rsp_if  rsp,
	epfm_cfg_if  cfg,
	output int   fail_count,
	output int   outstanding
);
	import epfm_pkg::*;

	// 1e6 Hz*us with 8 fraction bits
	localparam logic [63:0] HZ_US_Q8 = 64'd256_000_000;
	localparam logic [63:0] SPAN_SAT = 64'h7FFF_FFFF;

	typedef struct packed {
		logic signed [FREQ_W-1:0]   freq_q8;
		logic signed [PERIOD_W-1:0] period_us;
		status_t                    status;
		logic                       edge_accepted;
	} meter_reading_t;

	// model copy of the meter state and registers
	logic [TIME_W-1:0]   edge_stamp;
	logic [PERIOD_W-1:0] held_period;
	logic [DEB_W-1:0]    deb_us;
	logic [MAXP_W-1:0]   maxp_us;
	logic [MINP_W-1:0]   minp_us;

	meter_reading_t pending_readings[$];

	// apply one item to the model state and return the reading it produces
	function automatic meter_reading_t compute_reading(input action_t act,
			input logic [TIME_W-1:0] stamp, input logic chan_b);
		meter_reading_t res;
		logic [63:0] span;
		logic [PERIOD_W-1:0] p;
		logic [PERIOD_W-1:0] neg;
		logic [63:0] mag;
		logic [63:0] quo;
		res.edge_accepted = 1'b0;
		res.freq_q8 = '0;
		// edge handling with debounce and saturation
		if (act == ACT_EDGE && {16'd0, stamp} > {16'd0, edge_stamp} + {48'd0, deb_us}) begin
			span = {16'd0, stamp} - {16'd0, edge_stamp};
			if (span > SPAN_SAT)
				span = SPAN_SAT;
			p = span[PERIOD_W-1:0];
			if (chan_b)
				p = -p;
			held_period = p;
			edge_stamp = stamp;
			res.edge_accepted = 1'b1;
		end
		neg = -held_period;
		mag = held_period[PERIOD_W-1] ? {32'd0, neg} : {32'd0, held_period};
		// frequency against the updated state
		if ({16'd0, stamp} > {16'd0, edge_stamp} + {40'd0, maxp_us}) begin
			res.status = ST_TIMEOUT;
		end else if (mag < {48'd0, minp_us}) begin
			res.status = ST_BELOW_MIN;
			held_period = '0;
		end else if (held_period == '0) begin
			res.status = ST_NO_PERIOD;
		end else begin
			quo = HZ_US_Q8 / mag;
			if (held_period[PERIOD_W-1])
				quo = -quo;
			res.freq_q8 = quo[FREQ_W-1:0];
			res.status = ST_VALID;
		end
		res.period_us = held_period;
		return res;
	endfunction

	task automatic check_field(input string field, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			fail_count++;
			$error("%s: expected %0d, actual %0d", field, want_v, got_v);
		end
	endtask

	// watch the channels: register writes, result items, input items
	always @(posedge clk or negedge arst_n) begin
		meter_reading_t want;
		if (!arst_n) begin
			edge_stamp = '0;
			held_period = '0;
			deb_us = DEB_RESET;
			maxp_us = MAXP_RESET;
			minp_us = MINP_RESET;
			pending_readings.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_DEBOUNCE:   deb_us = cfg.data[DEB_W-1:0];
					REG_MAX_PERIOD: maxp_us = cfg.data[MAXP_W-1:0];
					REG_MIN_PERIOD: minp_us = cfg.data[MINP_W-1:0];
					default: ;
				endcase
			end
			// result item against the oldest reading waiting
			if (rsp.valid && rsp.ready) begin
				if (pending_readings.size() == 0) begin
					fail_count++;
					$error("result item with no input item outstanding");
				end else begin
					want = pending_readings.pop_front();
					check_field("freq_q8", $signed(want.freq_q8), $signed(rsp.freq_q8));
					check_field("period_us", $signed(want.period_us), $signed(rsp.period_us));
					check_field("status", want.status, rsp.status);
					check_field("edge_accepted", want.edge_accepted, rsp.edge_accepted);
				end
			end
			if (req.valid && req.ready)
				pending_readings.push_back(compute_reading(action_t'(req.action),
					req.now_us, req.level_b));
			outstanding = pending_readings.size();
		end
	end

endmodule

// ----- tb/tb_encoder_period_frequency_meter.sv -----
// testbench top of the encoder period and frequency meter: clock, reset, stimulus, verdict
// depends on epfm_pkg, epfm_if, the meter RTL and epfm_checker
`timescale 1ns / 100ps

module tb_encoder_period_frequency_meter;
	import epfm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int          SETTLE_CYCLES = 40;
	localparam int          SEGMENTS = 6;
	localparam int          SEGMENT_ITEMS = 335;
	// index past the register list, written to check that it does nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	// stamps of the directed part: a span past saturation, then one debounce later
	localparam logic [TIME_W-1:0] SAT_STAMP  = 48'd2147483754;
	localparam logic [TIME_W-1:0] LATE_STAMP = SAT_STAMP + 48'd65536;
	localparam logic [TIME_W-1:0] STAMP_MAX  = '1;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   outstanding;
	int unsigned cycle_count = 0;
	int   src_idle_pct = 31;
	int   snk_idle_pct = 45;

	// stimulus shaping only: register values and the last edge that counted
	longint            cur_deb = 0;
	longint            cur_maxp = 1000000;
	longint            cur_minp = 1;
	logic [TIME_W-1:0] edge_mark = '0;
	logic [TIME_W-1:0] last_stamp = '0;

	epfm_req_if req_ch ();
	epfm_rsp_if rsp_ch ();
	epfm_cfg_if cfg_ch ();

	encoder_period_frequency_meter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	epfm_checker meter_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_encoder_period_frequency_meter: done, errors");
			$finish;
		end
	end

	// hold off new items until every reading has come back
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// offer one item, with random gaps before it
	task automatic push_reading(input action_t act, input logic [TIME_W-1:0] stamp,
			input logic chan_b);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			req_ch.level_b <= 1'($urandom);
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.now_us <= stamp;
		req_ch.level_b <= chan_b;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		if (act == ACT_EDGE && longint'(stamp) > longint'(edge_mark) + cur_deb)
			edge_mark = stamp;
		last_stamp = stamp;
	endtask

	// register write, only once the meter is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_DEBOUNCE:   cur_deb = longint'(val[DEB_W-1:0]);
			REG_MAX_PERIOD: cur_maxp = longint'(val[MAXP_W-1:0]);
			REG_MIN_PERIOD: cur_minp = longint'(val[MINP_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic apply_setting(input longint deb, input longint maxp, input longint minp);
		write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
		write_reg(REG_MAX_PERIOD, CFG_DATA_W'(maxp));
		write_reg(REG_MIN_PERIOD, CFG_DATA_W'(minp));
	endtask

	initial begin
		action_t           act;
		logic              chan_b;
		logic [TIME_W-1:0] stamp;
		logic [63:0]       wide;
		longint            base;
		longint            off;
		longint            sum;
		int unsigned       pick;

		req_ch.valid = 1'b0;
		req_ch.action = ACT_EDGE;
		req_ch.now_us = '0;
		req_ch.level_b = 1'b0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_DEBOUNCE;
		cfg_ch.data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset registers: no period yet, equal-time edge, first edge, extreme frequency
		push_reading(ACT_QUERY, 48'd0, 1'b1);
		push_reading(ACT_EDGE, 48'd0, 1'b0);
		push_reading(ACT_EDGE, 48'd5, 1'b0);
		push_reading(ACT_EDGE, 48'd6, 1'b1);
		push_reading(ACT_EDGE, 48'd6, 1'b0);
		// query back in time, then either side of the timeout
		push_reading(ACT_QUERY, 48'd2, 1'b1);
		push_reading(ACT_QUERY, 48'd1000006, 1'b0);
		push_reading(ACT_QUERY, 48'd1000007, 1'b0);
		// saturated reverse period, then the largest stamp
		push_reading(ACT_EDGE, SAT_STAMP, 1'b1);
		push_reading(ACT_QUERY, STAMP_MAX, 1'b1);

		// widest registers, written with bits above their width
		write_reg(REG_DEBOUNCE, 24'hFF_FFFF);
		write_reg(REG_MAX_PERIOD, 24'hFF_FFFF);
		write_reg(REG_MIN_PERIOD, 24'hFF_FFFF);
		write_reg(REG_SPARE, 24'h5A_5A5A);
		push_reading(ACT_EDGE, SAT_STAMP + 48'd65535, 1'b0);
		push_reading(ACT_EDGE, LATE_STAMP, 1'b0);
		push_reading(ACT_QUERY, LATE_STAMP + 48'd16777215, 1'b1);
		push_reading(ACT_QUERY, LATE_STAMP + 48'd16777216, 1'b0);

		// short period below the minimum clears it; zero minimum then shows no period
		write_reg(REG_DEBOUNCE, 24'd0);
		push_reading(ACT_EDGE, LATE_STAMP + 48'd100, 1'b1);
		write_reg(REG_MIN_PERIOD, 24'hFF_0000);
		write_reg(REG_MAX_PERIOD, 24'd1000000);
		push_reading(ACT_QUERY, LATE_STAMP + 48'd100, 1'b0);
		push_reading(ACT_EDGE, LATE_STAMP + 48'd100, 1'b1);
		push_reading(ACT_EDGE, LATE_STAMP + 48'd101, 1'b0);
		// zero timeout window
		write_reg(REG_MAX_PERIOD, 24'd0);
		push_reading(ACT_QUERY, LATE_STAMP + 48'd101, 1'b1);
		push_reading(ACT_QUERY, LATE_STAMP + 48'd102, 1'b0);

		// random segments, each under its own register setting
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: apply_setting(0, 1000000, 1);
				1: apply_setting($urandom_range(200), $urandom_range(5000, 500),
					$urandom_range(50));
				2: apply_setting(0, 16777215, 0);
				3: apply_setting(65535, 0, 65535);
				4: apply_setting($urandom_range(65535), $urandom_range(16777215),
					$urandom_range(65535));
				default: apply_setting(10, 100000, 5);
			endcase
			case (seg / 2)
				0: begin
					src_idle_pct = 31;
					snk_idle_pct = 45;
				end
				1: begin
					src_idle_pct = 45;
					snk_idle_pct = 31;
				end
				default: begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				if ($urandom_range(49) == 0)
					drain();
				act = ($urandom_range(99) < 65) ? ACT_EDGE : ACT_QUERY;
				chan_b = 1'($urandom);
				base = longint'(edge_mark);
				pick = $urandom_range(99);
				// mostly clean edges past debounce, then the boundaries and noise
				if (pick < 45)
					off = cur_deb + 1 + longint'($urandom_range(400));
				else if (pick < 55)
					off = cur_deb + longint'($urandom_range(1));
				else if (pick < 63)
					off = cur_minp + longint'($urandom_range(2)) - 1;
				else if (pick < 71)
					off = cur_maxp + longint'($urandom_range(2)) - 1;
				else if (pick < 76)
					off = 64'sh7FFF_FFFF + longint'($urandom_range(2)) - 1;
				else if (pick < 82)
					off = -longint'($urandom_range(2000));
				else if (pick < 90)
					off = longint'($urandom_range(int'(cur_deb)));
				else begin
					base = longint'(last_stamp);
					off = longint'($urandom_range(50));
				end
				sum = base + off;
				if (sum < 0)
					sum = 0;
				stamp = sum[TIME_W-1:0];
				// a stamp anywhere in the range, as a query so edges stay reachable
				if (pick >= 96) begin
					act = ACT_QUERY;
					wide = {$urandom, $urandom};
					stamp = wide[TIME_W-1:0];
				end
				push_reading(act, stamp, chan_b);
			end
		end

		// wind down
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("tb_encoder_period_frequency_meter: done, clean");
		else
			$display("tb_encoder_period_frequency_meter: done, errors");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/epfm_pkg.sv
src/epfm_if.sv
src/epfm_cfg.sv
src/epfm_div.sv
src/encoder_period_frequency_meter.sv
tb/epfm_checker.sv
tb/tb_encoder_period_frequency_meter.sv
